### hw/rtl/cwat_pkg.sv
// shared types, widths and constants of the angle tracker
`default_nettype none

package cwat_pkg;

    // field widths
    localparam int IDX_W   = 8;
    localparam int PEAK_W  = 24;
    localparam int FS_W    = 23;
    localparam int ALPHA_W = 17;
    localparam int CONF_W  = 17;
    localparam int ANGLE_W = 16;
    localparam int RAW_W   = 10;
    localparam int QUOT_W  = 16;

    // configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 23;
    localparam logic [CFG_INDEX_W-1:0] CFG_FULL_SCALE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SMOOTHING  = 1'b1;

    // constants
    localparam logic [CONF_W-1:0]  ONE_Q16      = 17'd65536;
    localparam logic [FS_W-1:0]    FS_RESET     = 23'd200000;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET  = 17'd16384;
    localparam logic [RAW_W-1:0]   INDEX_CENTER = 10'd129;
    localparam int                 ANGLE_LIMIT  = 30720;
    localparam int                 ROUND_HALF   = 32768;

    // divider and datapath sizing
    localparam int DIV_STEPS = QUOT_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int MUL_W     = 18;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int FRAC_W    = 16;

    // queue sizing (depth is a power of two)
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // class of a peak as seen by the front end
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_ZERO = 2'd0;
    localparam kind_t KIND_FULL = 2'd1;
    localparam kind_t KIND_DIV  = 2'd2;

    // one queued transaction
    typedef struct packed {
        kind_t             kind;
        logic [RAW_W-1:0]  raw;
        logic [PEAK_W-1:0] peak;
    } item_t;

    // effective configuration
    typedef struct packed {
        logic [FS_W-1:0]    full_scale;
        logic [ALPHA_W-1:0] alpha;
    } cfg_t;

endpackage

`default_nettype wire

### hw/rtl/cwat_front.sv
// front end: accepts a transaction, classifies the peak and forms the raw angle
`default_nettype none

module cwat_front (
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [cwat_pkg::IDX_W-1:0]   peak_index,
    input  wire logic [cwat_pkg::PEAK_W-1:0]  peak_value,
    input  wire cwat_pkg::cfg_t               cfg,
    input  wire logic                         q_full,
    output logic                              push,
    output cwat_pkg::item_t                   push_item
);

    logic                          negative;
    logic                          saturated;
    logic [cwat_pkg::RAW_W-1:0]    centered;

    // handshake into the queue
    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    // peak classification
    assign negative  = peak_value[cwat_pkg::PEAK_W-1];
    assign saturated = !negative && (peak_value[cwat_pkg::FS_W-1:0] >= cfg.full_scale);

    // raw angle, (index - center) * 2
    assign centered = {{(cwat_pkg::RAW_W-cwat_pkg::IDX_W){1'b0}}, peak_index}
                      - cwat_pkg::INDEX_CENTER;

    always_comb
    begin
        push_item.peak = peak_value;
        push_item.raw  = {centered[cwat_pkg::RAW_W-2:0], 1'b0};
        if (negative)
        begin
            push_item.kind = cwat_pkg::KIND_ZERO;
        end
        else if (saturated)
        begin
            push_item.kind = cwat_pkg::KIND_FULL;
        end
        else
        begin
            push_item.kind = cwat_pkg::KIND_DIV;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/cwat_queue.sv
// short register queue between front end and back end
`default_nettype none

module cwat_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire cwat_pkg::item_t push_item,
    output logic                 full,
    input  wire logic            pop,
    output cwat_pkg::item_t      pop_item,
    output logic                 not_empty
);

    cwat_pkg::item_t                entry_reg [cwat_pkg::QUEUE_DEPTH];
    logic [cwat_pkg::PTR_W-1:0]     wr_ptr_reg;
    logic [cwat_pkg::PTR_W-1:0]     wr_ptr_next;
    logic [cwat_pkg::PTR_W-1:0]     rd_ptr_reg;
    logic [cwat_pkg::PTR_W-1:0]     rd_ptr_next;
    logic [cwat_pkg::CNT_W-1:0]     count_reg;
    logic [cwat_pkg::CNT_W-1:0]     count_next;
    logic                           do_push;
    logic                           do_pop;

    assign full      = (count_reg == cwat_pkg::CNT_W'(cwat_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_item  = entry_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/cwat_back.sv
// back end: restoring divider, shared multiplier sequencer and output register
`default_nettype none

module cwat_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire cwat_pkg::cfg_t                cfg,
    input  wire logic                          q_valid,
    input  wire cwat_pkg::item_t               q_item,
    output logic                               pop,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [cwat_pkg::ANGLE_W-1:0] angle_estimate,
    output logic [cwat_pkg::CONF_W-1:0]        confidence,
    output logic signed [cwat_pkg::RAW_W-1:0]  raw_angle,
    output logic signed [cwat_pkg::PEAK_W-1:0] peak_echo
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_M1   = 3'd2;
    localparam logic [2:0] ST_M2   = 3'd3;
    localparam logic [2:0] ST_CONF = 3'd4;
    localparam logic [2:0] ST_M3   = 3'd5;
    localparam logic [2:0] ST_M4   = 3'd6;
    localparam logic [2:0] ST_ANG  = 3'd7;

    localparam int SHIFT_W = cwat_pkg::ACC_W - cwat_pkg::FRAC_W;

    // control state
    logic [2:0]                          state_reg;
    logic [2:0]                          state_next;
    logic [cwat_pkg::STEP_W-1:0]         step_reg;
    logic [cwat_pkg::STEP_W-1:0]         step_next;
    logic [cwat_pkg::CONF_W-1:0]         fc_reg;
    logic [cwat_pkg::CONF_W-1:0]         fc_next;
    logic signed [cwat_pkg::ANGLE_W-1:0] held_reg;
    logic signed [cwat_pkg::ANGLE_W-1:0] held_next;
    logic                                out_valid_reg;
    logic                                out_valid_next;

    // datapath
    cwat_pkg::item_t                     item_reg;
    logic [cwat_pkg::FS_W-1:0]           rem_reg;
    logic [cwat_pkg::FS_W-1:0]           rem_next;
    logic [cwat_pkg::QUOT_W-1:0]         quot_reg;
    logic [cwat_pkg::QUOT_W-1:0]         quot_next;
    logic [cwat_pkg::CONF_W-1:0]         inst_reg;
    logic [cwat_pkg::CONF_W-1:0]         inst_next;
    logic [cwat_pkg::CONF_W-1:0]         conf_reg;
    logic [cwat_pkg::CONF_W-1:0]         conf_next;
    logic signed [cwat_pkg::PROD_W-1:0]  prod_reg;
    logic signed [cwat_pkg::ACC_W-1:0]   acc_reg;
    logic signed [cwat_pkg::ANGLE_W-1:0] angle_out_reg;
    logic [cwat_pkg::CONF_W-1:0]         conf_out_reg;
    logic [cwat_pkg::RAW_W-1:0]          raw_out_reg;
    logic [cwat_pkg::PEAK_W-1:0]         peak_out_reg;

    logic [cwat_pkg::FS_W:0]             rem_shift;
    logic                                fits;
    logic signed [cwat_pkg::MUL_W-1:0]   mul_a;
    logic signed [cwat_pkg::MUL_W-1:0]   mul_b;
    logic signed [cwat_pkg::PROD_W-1:0]  mul_p;
    logic signed [cwat_pkg::ACC_W-1:0]   sum;
    logic signed [SHIFT_W-1:0]           sum_hi;
    logic signed [cwat_pkg::ANGLE_W-1:0] angle_val;
    logic                                out_free;
    logic                                load_out;

    assign pop      = (state_reg == ST_IDLE) && q_valid;
    assign out_free = !out_valid_reg || !out_stall;
    assign load_out = (state_reg == ST_ANG) && out_free;

    // one restoring divide step
    assign rem_shift = {rem_reg, 1'b0};
    assign fits      = rem_shift >= {1'b0, cfg.full_scale};

    always_comb
    begin
        if (fits)
        begin
            rem_next = cwat_pkg::FS_W'(rem_shift - {1'b0, cfg.full_scale});
        end
        else
        begin
            rem_next = rem_shift[cwat_pkg::FS_W-1:0];
        end
        quot_next = {quot_reg[cwat_pkg::QUOT_W-2:0], fits};
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_M1:
            begin
                mul_a = {1'b0, cwat_pkg::ONE_Q16 - cfg.alpha};
                mul_b = {1'b0, fc_reg};
            end
            ST_M2:
            begin
                mul_a = {1'b0, cfg.alpha};
                mul_b = {1'b0, inst_reg};
            end
            ST_M3:
            begin
                mul_a = {1'b0, conf_reg};
                mul_b = {item_reg.raw, 8'b0};
            end
            ST_M4:
            begin
                mul_a = {1'b0, cwat_pkg::ONE_Q16 - conf_reg};
                mul_b = {{(cwat_pkg::MUL_W-cwat_pkg::ANGLE_W){held_reg[cwat_pkg::ANGLE_W-1]}},
                         held_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // rounded sum of the two products, floor shift by sixteen
    assign sum    = acc_reg + cwat_pkg::ACC_W'(prod_reg)
                    + cwat_pkg::ACC_W'(cwat_pkg::ROUND_HALF);
    assign sum_hi = sum[cwat_pkg::ACC_W-1:cwat_pkg::FRAC_W];

    // filtered confidence with saturation
    always_comb
    begin
        if (sum_hi > SHIFT_W'($signed({1'b0, cwat_pkg::ONE_Q16})))
        begin
            conf_next = cwat_pkg::ONE_Q16;
        end
        else
        begin
            conf_next = sum_hi[cwat_pkg::CONF_W-1:0];
        end
    end

    // angle clamp
    always_comb
    begin
        if (sum_hi > SHIFT_W'(cwat_pkg::ANGLE_LIMIT))
        begin
            angle_val = cwat_pkg::ANGLE_W'(cwat_pkg::ANGLE_LIMIT);
        end
        else if (sum_hi < -SHIFT_W'(cwat_pkg::ANGLE_LIMIT))
        begin
            angle_val = -cwat_pkg::ANGLE_W'(cwat_pkg::ANGLE_LIMIT);
        end
        else
        begin
            angle_val = sum_hi[cwat_pkg::ANGLE_W-1:0];
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        fc_next        = fc_reg;
        held_next      = held_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    step_next  = '0;
                    state_next = (q_item.kind == cwat_pkg::KIND_DIV) ? ST_DIV : ST_M1;
                end
            end
            ST_DIV:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == cwat_pkg::STEP_W'(cwat_pkg::DIV_STEPS - 1))
                begin
                    state_next = ST_M1;
                end
            end
            ST_M1:
            begin
                state_next = ST_M2;
            end
            ST_M2:
            begin
                state_next = ST_CONF;
            end
            ST_CONF:
            begin
                fc_next    = conf_next;
                state_next = ST_M3;
            end
            ST_M3:
            begin
                state_next = ST_M4;
            end
            ST_M4:
            begin
                state_next = ST_ANG;
            end
            ST_ANG:
            begin
                if (out_free)
                begin
                    held_next      = angle_val;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // instantaneous confidence source
    always_comb
    begin
        inst_next = inst_reg;
        if (pop)
        begin
            inst_next = (q_item.kind == cwat_pkg::KIND_FULL) ? cwat_pkg::ONE_Q16 : '0;
        end
        else if ((state_reg == ST_DIV) &&
                 (step_reg == cwat_pkg::STEP_W'(cwat_pkg::DIV_STEPS - 1)))
        begin
            inst_next = {1'b0, quot_next};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            fc_reg        <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            fc_reg        <= fc_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        inst_reg <= inst_next;
        if (pop)
        begin
            item_reg <= q_item;
            rem_reg  <= q_item.peak[cwat_pkg::FS_W-1:0];
            quot_reg <= '0;
        end
        else if (state_reg == ST_DIV)
        begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
        if (state_reg == ST_M1 || state_reg == ST_M3)
        begin
            acc_reg <= '0;
        end
        else if (state_reg == ST_M2 || state_reg == ST_M4)
        begin
            acc_reg <= cwat_pkg::ACC_W'(prod_reg);
        end
        // product holds while the result waits for a free output register
        if (state_reg inside {ST_M1, ST_M2, ST_M3, ST_M4})
        begin
            prod_reg <= mul_p;
        end
        if (state_reg == ST_CONF)
        begin
            conf_reg <= conf_next;
        end
        if (load_out)
        begin
            angle_out_reg <= angle_val;
            conf_out_reg  <= conf_reg;
            raw_out_reg   <= item_reg.raw;
            peak_out_reg  <= item_reg.peak;
        end
    end

    assign out_valid      = out_valid_reg;
    assign angle_estimate = angle_out_reg;
    assign confidence     = conf_out_reg;
    assign raw_angle      = raw_out_reg;
    assign peak_echo      = peak_out_reg;

endmodule

`default_nettype wire

### hw/rtl/confidence_weighted_angle_tracker_top.sv
// Confidence-weighted angle tracker, top level.
// An in-range peak passes the 16-step restoring divider and then the shared
// multiplier sequence (M1, M2, CONF, M3, M4, ANG) in the back end; a negative
// or saturated peak skips the divider and goes straight to that sequence.
// The back end takes a new transaction only after it has delivered the last.
// Reset: asynchronous, active low; clears queue, state, config to defaults.
`default_nettype none

module confidence_weighted_angle_tracker_top (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [cwat_pkg::IDX_W-1:0]          peak_index,
    input  wire logic signed [cwat_pkg::PEAK_W-1:0]  peak_value,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic signed [cwat_pkg::ANGLE_W-1:0]      angle_estimate,
    output logic [cwat_pkg::CONF_W-1:0]              confidence,
    output logic signed [cwat_pkg::RAW_W-1:0]        raw_angle,
    output logic signed [cwat_pkg::PEAK_W-1:0]       peak_echo,
    input  wire logic                                cfg_write,
    input  wire logic [cwat_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [cwat_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [cwat_pkg::FS_W-1:0]    full_scale_reg;
    logic [cwat_pkg::ALPHA_W-1:0] smoothing_reg;
    cwat_pkg::cfg_t               cfg;
    logic                         q_full;
    logic                         q_not_empty;
    logic                         push;
    logic                         pop;
    cwat_pkg::item_t              push_item;
    cwat_pkg::item_t              pop_item;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_scale_reg <= cwat_pkg::FS_RESET;
            smoothing_reg  <= cwat_pkg::ALPHA_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                cwat_pkg::CFG_FULL_SCALE:
                begin
                    full_scale_reg <= cfg_data[cwat_pkg::FS_W-1:0];
                end
                cwat_pkg::CFG_SMOOTHING:
                begin
                    smoothing_reg <= cfg_data[cwat_pkg::ALPHA_W-1:0];
                end
                default:
                begin
                    full_scale_reg <= full_scale_reg;
                end
            endcase
        end
    end

    // effective values: zero full scale acts as one, alpha saturates at one
    always_comb
    begin
        cfg.full_scale = (full_scale_reg == '0) ? cwat_pkg::FS_W'(1) : full_scale_reg;
        cfg.alpha      = (smoothing_reg > cwat_pkg::ONE_Q16) ? cwat_pkg::ONE_Q16
                                                             : smoothing_reg;
    end

    cwat_front u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .peak_index (peak_index),
        .peak_value (peak_value),
        .cfg        (cfg),
        .q_full     (q_full),
        .push       (push),
        .push_item  (push_item)
    );

    cwat_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .not_empty (q_not_empty)
    );

    cwat_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .q_valid        (q_not_empty),
        .q_item         (pop_item),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .angle_estimate (angle_estimate),
        .confidence     (confidence),
        .raw_angle      (raw_angle),
        .peak_echo      (peak_echo)
    );

    // filtered confidence never passes one
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (confidence <= cwat_pkg::ONE_Q16))
        else $error("confidence above one");

    // angle estimate stays inside the clamp
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((angle_estimate <= 16'sd30720) && (angle_estimate >= -16'sd30720)))
        else $error("angle estimate outside clamp");

    // raw angle is always an even number of degrees
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !raw_angle[0])
        else $error("raw angle odd");

endmodule

`default_nettype wire
